[sv/slbs_pkg.sv]
// Shared types and constants for the sorted lower-bound search block.
package slbs_pkg;

   localparam int DATA_W = 32;
   localparam int IDX_W  = 10;
   localparam int CNT_W  = 11;
   localparam int POS_W  = 11;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   // token control handed from cell to cell
   typedef struct packed {
      logic valid;   // a search token sits here
      logic live;    // search range still non-empty, a probe is pending
   } slbs_ctl_type;

endpackage

[sv/slbs_table.sv]
// Table storage: one write port, one registered read port.
module slbs_table #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [slbs_pkg::DATA_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [slbs_pkg::DATA_W-1:0] rd_data
);
   import slbs_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/slbs_cell.sv]
// One halving step of the search: holds a token and passes the narrowed range on.
module slbs_cell #(
   parameter int CW = 11,
   parameter int AW = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  slbs_pkg::slbs_ctl_type       up_ctl,
   input  logic [CW-1:0]                up_lo,
   input  logic [CW-1:0]                up_hix,
   input  logic [CW-1:0]                up_ans,
   input  logic [AW-1:0]                up_mid,
   input  logic [slbs_pkg::DATA_W-1:0]  key,
   input  logic [slbs_pkg::DATA_W-1:0]  rd_data,
   output slbs_pkg::slbs_ctl_type       dn_ctl,
   output logic [CW-1:0]                dn_lo,
   output logic [CW-1:0]                dn_hix,
   output logic [CW-1:0]                dn_ans,
   output logic [AW-1:0]                dn_mid
);
   import slbs_pkg::*;

   slbs_ctl_type  ctl_ff;
   logic [CW-1:0] lo_ff, hix_ff, ans_ff;
   logic [AW-1:0] mid_ff;

   logic [CW-1:0] lo_n, hix_n, ans_n;
   logic [CW:0]   sum_n;
   logic          ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= up_lo;
      hix_ff <= up_hix;
      ans_ff <= up_ans;
      mid_ff <= up_mid;
   end

   // range is [lo, hix); rd_data holds the entry at mid_ff
   assign ge = $signed(rd_data) >= $signed(key);

   always_comb begin
      lo_n  = lo_ff;
      hix_n = hix_ff;
      ans_n = ans_ff;
      if (ctl_ff.live) begin
         if (ge) begin
            ans_n = CW'(mid_ff);
            hix_n = CW'(mid_ff);
         end else begin
            lo_n = CW'(mid_ff) + CW'(1);
         end
      end
   end

   // floor((lo + hi) / 2) with hi = hix - 1
   assign sum_n = ({1'b0, lo_n} + {1'b0, hix_n} - (CW+1)'(1)) >> 1;

   assign dn_ctl.valid = ctl_ff.valid;
   assign dn_ctl.live  = ctl_ff.live && (lo_n < hix_n);
   assign dn_lo        = lo_n;
   assign dn_hix       = hix_n;
   assign dn_ans       = ans_n;
   assign dn_mid       = AW'(sum_n);

endmodule

[sv/sorted_lower_bound_search_top.sv]
// Lower-bound search over a sorted table, built as a chain of halving cells.
// A query token walks the whole chain of cells and then the output register to rsp_valid;
// req stays stalled while a token is in the chain, so a new request waits for the last query to
// leave it; a write lands in the table when accepted; a result queued behind a stalled one stalls req.
// Reset clears the element count and all control state; table contents stay
// undefined until written. No clearing pass.
module sorted_lower_bound_search_top #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_action,
   input  logic [slbs_pkg::IDX_W-1:0]  req_entry_index,
   input  logic [slbs_pkg::DATA_W-1:0] req_entry_value,
   input  logic [slbs_pkg::DATA_W-1:0] req_query_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [slbs_pkg::POS_W-1:0]  rsp_position,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [slbs_pkg::CNT_W-1:0]  csr_element_count
);
   import slbs_pkg::*;

   localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int NCELL = CW;

   // count register, saturated at the table depth
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (csr_valid && csr_ready) begin
         if (32'(csr_element_count) > 32'(TABLE_DEPTH)) begin
            count_in = CW'(TABLE_DEPTH);
         end else begin
            count_in = CW'(csr_element_count);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign csr_ready = 1'b1;

   // input side
   logic req_accept, launch, wr_en;
   logic chain_busy;
   logic hold_valid_ff, hold_valid_in;

   assign req_stall  = chain_busy || hold_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign launch     = req_accept && (req_action == ACTION_QUERY);
   assign wr_en      = req_accept && (req_action == ACTION_WRITE)
                       && (32'(req_entry_index) < 32'(TABLE_DEPTH));

   logic [DATA_W-1:0] key_ff;

   always_ff @(posedge clock) begin
      if (launch) begin
         key_ff <= req_query_value;
      end
   end

   // cell chain
   slbs_ctl_type  ctl_w [NCELL+1];
   logic [CW-1:0] lo_w  [NCELL+1];
   logic [CW-1:0] hix_w [NCELL+1];
   logic [CW-1:0] ans_w [NCELL+1];
   logic [AW-1:0] mid_w [NCELL+1];
   logic [AW-1:0] addr_m [NCELL];
   logic [NCELL-1:0] cell_valid;

   logic [CW:0]       mid0_sum;
   logic [DATA_W-1:0] rd_data;
   logic [AW-1:0]     rd_addr;

   assign mid0_sum = ({1'b0, count_ff} - (CW+1)'(1)) >> 1;

   assign ctl_w[0].valid = launch;
   assign ctl_w[0].live  = (count_ff != '0);
   assign lo_w[0]        = '0;
   assign hix_w[0]       = count_ff;
   assign ans_w[0]       = count_ff;
   assign mid_w[0]       = AW'(mid0_sum);

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      slbs_cell #(
         .CW (CW),
         .AW (AW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .up_ctl  (ctl_w[i]),
         .up_lo   (lo_w[i]),
         .up_hix  (hix_w[i]),
         .up_ans  (ans_w[i]),
         .up_mid  (mid_w[i]),
         .key     (key_ff),
         .rd_data (rd_data),
         .dn_ctl  (ctl_w[i+1]),
         .dn_lo   (lo_w[i+1]),
         .dn_hix  (hix_w[i+1]),
         .dn_ans  (ans_w[i+1]),
         .dn_mid  (mid_w[i+1])
      );
      // only one token is ever in flight, so masked addresses can be ORed
      assign addr_m[i]     = ctl_w[i+1].valid ? mid_w[i+1] : '0;
      assign cell_valid[i] = ctl_w[i+1].valid;
   end

   assign chain_busy = |cell_valid;

   always_comb begin
      rd_addr = launch ? mid_w[0] : '0;
      for (int i = 0; i < NCELL; i++) begin
         rd_addr = rd_addr | addr_m[i];
      end
   end

   slbs_table #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (req_entry_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register plus one holding slot
   logic             finish;
   logic [POS_W-1:0] fin_pos;
   logic             rsp_take;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [POS_W-1:0] hold_pos_ff, hold_pos_in;

   assign finish   = ctl_w[NCELL].valid;
   assign fin_pos  = POS_W'({1'b0, ans_w[NCELL]} + (CW+1)'(1));
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_pos_in    = rsp_pos_ff;
      hold_valid_in = hold_valid_ff;
      hold_pos_in   = hold_pos_ff;
      if (rsp_take) begin
         rsp_valid_in  = hold_valid_ff;
         rsp_pos_in    = hold_pos_ff;
         hold_valid_in = 1'b0;
      end
      if (finish) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_pos_in   = fin_pos;
         end else begin
            hold_valid_in = 1'b1;
            hold_pos_in   = fin_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pos_ff  <= rsp_pos_in;
      hold_pos_ff <= hold_pos_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;

endmodule

[sv/slbs_checker.sv]
// Port-level checks for the search block, bound to the top level.
module slbs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_action,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [slbs_pkg::POS_W-1:0]  rsp_position
);
   import slbs_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position))
      else $error("stalled result beat changed");

   // positions are 1-based
   a_pos_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_position != '0)
      else $error("result position is zero");

   // a query occupies the search chain, so the next beat must wait
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_action == ACTION_QUERY) |=> req_stall)
      else $error("request taken while a search is running");

   // a write beat never makes a result appear
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_action == ACTION_WRITE) && !rsp_valid
      |=> !rsp_valid)
      else $error("write beat produced a result");

endmodule

bind sorted_lower_bound_search_top slbs_checker u_slbs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_action   (req_action),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_position (rsp_position)
);

[sim/tb.sv]
// Testbench for the sorted lower-bound search block: self-checking regression.
`timescale 1ns / 1ps

module tb;
   import slbs_pkg::*;

   localparam int DEPTH   = 1024;
   localparam int MIN_VAL = 32'sh8000_0000;
   localparam int MAX_VAL = 32'sh7fff_ffff;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_action;
   logic [IDX_W-1:0]    req_entry_index;
   logic [DATA_W-1:0]   req_entry_value;
   logic [DATA_W-1:0]   req_query_value;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [POS_W-1:0]    rsp_position;
   logic                csr_valid;
   logic                csr_ready;
   logic [CNT_W-1:0]    csr_element_count;

   // shadow of the block: table contents and the element count
   int                  entries_mirror[DEPTH];
   int unsigned         count_mirror;
   logic [POS_W-1:0]    pending_positions[$];

   bit                  quiet;
   int                  sender_idle_pct;
   int                  sink_stall_pct;
   int                  stall_left;
   int                  mismatch_count;
   int                  positions_checked;
   int                  queries_sent;
   int                  writes_sent;
   int                  count_settings;

   sorted_lower_bound_search_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_entry_index   (req_entry_index),
      .req_entry_value   (req_entry_value),
      .req_query_value   (req_query_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_position      (rsp_position),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_element_count (csr_element_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // binary search in the same probe order as the hardware
   function automatic logic [POS_W-1:0] lower_bound_position(input int key);
      int n;
      int lo;
      int hi;
      int mid;
      int ans;
      n  = (count_mirror > DEPTH) ? DEPTH : int'(count_mirror);
      lo = 0;
      hi = n - 1;
      ans = n;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (entries_mirror[mid] >= key) begin
            ans = mid;
            hi  = mid - 1;
         end else begin
            lo = mid + 1;
         end
      end
      return POS_W'(ans + 1);
   endfunction

   task automatic report_mismatch(input string why, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("MISMATCH %s: expected %0d got %0d at %0t", why, want, got, $realtime);
   endtask

   // result checker
   always @(posedge clock) begin : check_positions
      logic [POS_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_positions.size() == 0) begin
            report_mismatch("result with nothing pending", -1, int'(rsp_position));
         end else begin
            want = pending_positions.pop_front();
            positions_checked++;
            if (rsp_position !== want)
               report_mismatch("position", int'(want), int'(rsp_position));
         end
      end
   end

   // result-side backpressure in bursts
   initial begin
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 99) < sink_stall_pct) begin
            rsp_stall  = 1'b1;
            stall_left = $urandom_range(1, 12) - 1;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // one request beat; the shadow is updated when the beat is taken
   task automatic issue_request(input logic act, input logic [IDX_W-1:0] idx,
                                input int wval, input int qval);
      int gap;
      if (!quiet && $urandom_range(0, 99) < sender_idle_pct) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_valid       = 1'b0;
         req_action      = 1'($urandom);
         req_entry_index = IDX_W'($urandom);
         req_entry_value = $urandom;
         req_query_value = $urandom;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       = 1'b1;
      req_action      = act;
      req_entry_index = idx;
      req_entry_value = wval;
      req_query_value = qval;
      do @(posedge clock); while (req_stall);
      if (act == ACTION_QUERY) begin
         pending_positions.push_back(lower_bound_position(qval));
         queries_sent++;
      end else begin
         entries_mirror[idx] = wval;
         writes_sent++;
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_positions.size() != 0) @(posedge clock);
      // extra settling time; a trailing write is already in the table once taken
      repeat (20) @(posedge clock);
   endtask

   task automatic set_element_count(input int unsigned n);
      wait_idle();
      @(negedge clock);
      csr_valid         = 1'b1;
      csr_element_count = CNT_W'(n);
      do @(posedge clock); while (!csr_ready);
      count_mirror = n;
      count_settings++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic load_entries(input int n, input bit dup_heavy, input bit shuffled);
      int vals[$];
      int m;
      m = (n > DEPTH) ? DEPTH : n;
      for (int i = 0; i < m; i++)
         vals.push_back(dup_heavy ? $urandom_range(0, 20) - 10 : int'($urandom));
      if (!shuffled)
         vals.sort();
      for (int i = 0; i < m; i++)
         issue_request(ACTION_WRITE, IDX_W'(i), vals[i], $urandom);
   endtask

   function automatic int pick_query();
      int n;
      int hit;
      n = (count_mirror > DEPTH) ? DEPTH : int'(count_mirror);
      if (n == 0)
         return int'($urandom);
      hit = entries_mirror[$urandom_range(0, n - 1)];
      case ($urandom_range(0, 5))
         0: return hit;
         1: return hit - 1;
         2: return hit + 1;
         3: return MIN_VAL;
         4: return MAX_VAL;
         default: return int'($urandom);
      endcase
   endfunction

   task automatic run_queries(input int k, input bit with_noise);
      repeat (k) begin
         // stray writes break the sorted order on purpose
         if (with_noise && $urandom_range(0, 9) == 0)
            issue_request(ACTION_WRITE, IDX_W'($urandom), $urandom, $urandom);
         else
            issue_request(ACTION_QUERY, IDX_W'($urandom), $urandom, pick_query());
      end
   endtask

   task automatic test_empty_table();
      set_element_count(0);
      issue_request(ACTION_QUERY, '0, 0, MIN_VAL);
      issue_request(ACTION_QUERY, '1, 0, 0);
      issue_request(ACTION_QUERY, '0, 0, MAX_VAL);
   endtask

   task automatic test_single_entry();
      set_element_count(1);
      issue_request(ACTION_WRITE, '0, 0, $urandom);
      issue_request(ACTION_QUERY, '0, 0, -1);
      issue_request(ACTION_QUERY, '0, 0, 0);
      issue_request(ACTION_QUERY, '0, 0, 1);
      issue_request(ACTION_QUERY, '0, 0, MAX_VAL);
      issue_request(ACTION_WRITE, '0, MAX_VAL, $urandom);
      issue_request(ACTION_QUERY, '0, 0, MAX_VAL);
      issue_request(ACTION_QUERY, '0, 0, MIN_VAL);
   endtask

   task automatic test_duplicates_and_extremes();
      int vals[6];
      vals = '{MIN_VAL, MIN_VAL, -5, 7, 7, MAX_VAL};
      set_element_count(6);
      for (int i = 0; i < 6; i++)
         issue_request(ACTION_WRITE, IDX_W'(i), vals[i], $urandom);
      issue_request(ACTION_QUERY, '0, 0, MIN_VAL);
      issue_request(ACTION_QUERY, '0, 0, MIN_VAL + 1);
      issue_request(ACTION_QUERY, '0, 0, 0);
      issue_request(ACTION_QUERY, '0, 0, 7);
      issue_request(ACTION_QUERY, '0, 0, 8);
      issue_request(ACTION_QUERY, '0, 0, MAX_VAL);
   endtask

   // fills every entry, so any count is safe to search from here on
   task automatic test_full_table();
      sender_idle_pct = 15;
      sink_stall_pct  = 15;
      load_entries(DEPTH, 1'b0, 1'b0);
      set_element_count(DEPTH);
      run_queries(40, 1'b0);
      set_element_count(2047);
      run_queries(10, 1'b0);
      set_element_count($urandom_range(DEPTH + 1, 2046));
      run_queries(10, 1'b0);
   endtask

   task automatic test_random_tables();
      int n;
      int pick;
      while (queries_sent + writes_sent < 1400) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: n = 0;
            1: n = 1;
            2: n = $urandom_range(41, 300);
            default: n = $urandom_range(2, 40);
         endcase
         case ($urandom_range(0, 2))
            0: sender_idle_pct = 0;
            1: sender_idle_pct = 15;
            default: sender_idle_pct = 40;
         endcase
         case ($urandom_range(0, 2))
            0: sink_stall_pct = 0;
            1: sink_stall_pct = 15;
            default: sink_stall_pct = 40;
         endcase
         set_element_count(n);
         pick = $urandom_range(0, 19);
         if (pick < 15)
            load_entries(n, 1'($urandom_range(0, 1)), 1'b0);
         else if (pick < 18)
            load_entries(n, 1'($urandom_range(0, 1)), 1'b1);
         run_queries($urandom_range(5, 20), $urandom_range(0, 3) == 0);
      end
   endtask

   // requests offered with no idling and results taken with no backpressure
   task automatic test_streaming();
      quiet = 1'b1;
      sender_idle_pct = 0;
      sink_stall_pct  = 0;
      set_element_count(64);
      load_entries(64, 1'b0, 1'b0);
      run_queries(60, 1'b0);
   endtask

   initial begin
      int spin;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = ACTION_WRITE;
      req_entry_index   = '0;
      req_entry_value   = '0;
      req_query_value   = '0;
      csr_valid         = 1'b0;
      csr_element_count = '0;
      quiet             = 1'b0;
      sender_idle_pct   = 0;
      sink_stall_pct    = 0;
      count_mirror      = 0;
      mismatch_count    = 0;
      positions_checked = 0;
      queries_sent      = 0;
      writes_sent       = 0;
      count_settings    = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_single_entry();
      test_duplicates_and_extremes();
      test_full_table();
      test_random_tables();
      test_streaming();

      @(negedge clock);
      req_valid = 1'b0;
      for (spin = 0; spin < 5000 && pending_positions.size() != 0; spin++)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (pending_positions.size() != 0)
         report_mismatch("positions never returned", pending_positions.size(), 0);

      $display("Covered %0d table writes and %0d lower-bound queries over %0d count settings;",
               writes_sent, queries_sent, count_settings);
      $display("%0d positions checked, %0d mismatches.", positions_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
